// ===== design/min_distance_point_thinning_macros.svh =====
// Assertion macros shared by the point thinning block.
`ifndef MIN_DISTANCE_POINT_THINNING_MACROS_SVH
`define MIN_DISTANCE_POINT_THINNING_MACROS_SVH

// The consequence must hold in the same cycle as the condition.
`define MDPT_ASSERT_SAME(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (cons)) \
    else $error(msg);

// The consequence sequence starts in the cycle after the condition.
`define MDPT_ASSERT_NEXT(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> cons) \
    else $error(msg);

`endif

// ===== design/mdpt_pkg.sv =====
`timescale 1ns / 1ps

package mdpt_pkg;

  localparam int COORD_W     = 12;
  localparam int DIM_W       = 13;
  localparam int LIMIT_W     = 26;
  localparam int COUNT_OUT_W = 11;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 26;
  localparam int SQ_W        = 2 * COORD_W;
  localparam int ENTRY_W     = 2 * COORD_W;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_OFFER = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    STAT_KEPT   = 3'd0,
    STAT_CLOSE  = 3'd1,
    STAT_CORNER = 3'd2,
    STAT_FULL   = 3'd3,
    STAT_START  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEED,
    ST_SCAN,
    ST_DRAIN
  } state_e;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIST_SQ  = 2'd2;

  localparam logic [DIM_W-1:0]   RST_IMAGE_WIDTH  = 13'd640;
  localparam logic [DIM_W-1:0]   RST_IMAGE_HEIGHT = 13'd480;
  localparam logic [LIMIT_W-1:0] RST_MIN_DIST_SQ  = 26'd100;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } point_t;

  typedef struct packed {
    cmd_e               command;
    logic [COORD_W-1:0] point_x;
    logic [COORD_W-1:0] point_y;
  } in_t;

  typedef struct packed {
    status_e                status;
    logic [COUNT_OUT_W-1:0] kept_count;
  } out_t;

  typedef struct packed {
    logic pending;
    logic close;
  } dist_stat_t;

endpackage

// ===== design/min_distance_point_thinning.sv =====
`timescale 1ns / 1ps
// Channel   | Handshake            | Payload
// ----------+----------------------+------------------------------------------
// command   | start, busy          | cmd_i   (command, point_x, point_y)
// result    | done_o strobe        | res_o   (status, kept_count)
// config    | cfg_we_i             | cfg_idx_i, cfg_wdata_i
//
// A start command writes the four seeded corners to the list memory in turn.
// A corner point is answered from the idle state without a scan; any other point, with N >= 1 kept points,
// is compared with each of them, read through the single read port of the list memory one entry per cycle.
// A point offered to an empty list goes straight to the drain state and is kept without a scan.
// For a start or a scanned point the result strobe rises as busy falls; a corner point never raises busy.
// Reset clears the count and loads the register defaults; the list memory is not cleared.
// The receiver cannot stall; each result is shown for one cycle only.

`include "min_distance_point_thinning_macros.svh"

module min_distance_point_thinning #(
  parameter int MAX_POINTS = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  input  mdpt_pkg::in_t                   cmd_i,
  output logic                            busy,
  output logic                            done_o,
  output mdpt_pkg::out_t                  res_o,
  input  logic                            cfg_we_i,
  input  logic [mdpt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mdpt_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  import mdpt_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  state_e             state_q, state_d;
  logic [AW-1:0]      idx_q, idx_d;
  logic [CW-1:0]      count_q, count_d;
  logic [1:0]         seed_q, seed_d;
  point_t             pt_q, pt_d;
  logic               rd_vld_q, rd_vld_d;
  logic               done_q, done_d;
  out_t               res_q, res_d;
  logic [DIM_W-1:0]   width_q, height_q;
  logic [LIMIT_W-1:0] limit_q;

  logic               accept, corner, clear, scan_last, drained;
  logic [DIM_W-1:0]   width_m1, height_m1;
  logic [COORD_W-1:0] right, bottom;
  logic               we, re;
  logic [AW-1:0]      waddr;
  point_t             wpoint, rpoint;
  logic [CW-1:0]      count_next;
  logic [CW+COUNT_OUT_W-1:0] count_wide;
  dist_stat_t         dist_stat;

  assign accept    = start && !busy;
  assign width_m1  = width_q - DIM_W'(1);
  assign height_m1 = height_q - DIM_W'(1);
  assign right     = width_m1[COORD_W-1:0];
  assign bottom    = height_m1[COORD_W-1:0];
  assign corner    = ((cmd_i.point_x == '0) || (cmd_i.point_x == right))
                  && ((cmd_i.point_y == '0) || (cmd_i.point_y == bottom));
  assign scan_last = (CW'(idx_q) == count_q - CW'(1));
  assign drained   = !rd_vld_q && !dist_stat.pending;
  assign clear     = accept;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (cmd_i.command == CMD_START) begin
            state_d = ST_SEED;
          end else if (!corner) begin
            state_d = (count_q == '0) ? ST_DRAIN : ST_SCAN;
          end
        end
      end
      ST_SEED: begin
        if (seed_q == 2'd3) begin
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drained) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    idx_d      = idx_q;
    count_d    = count_q;
    seed_d     = seed_q;
    pt_d       = pt_q;
    rd_vld_d   = 1'b0;
    done_d     = 1'b0;
    res_d      = res_q;
    we         = 1'b0;
    re         = 1'b0;
    waddr      = count_q[AW-1:0];
    wpoint     = pt_q;
    count_next = count_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          seed_d = 2'd0;
          idx_d  = '0;
          pt_d   = '{x: cmd_i.point_x, y: cmd_i.point_y};
          if ((cmd_i.command == CMD_OFFER) && corner) begin
            done_d       = 1'b1;
            res_d.status = STAT_CORNER;
            count_next   = count_q;
          end
        end
      end
      ST_SEED: begin
        we     = 1'b1;
        waddr  = AW'(seed_q);
        seed_d = seed_q + 2'd1;
        case (seed_q)
          2'd0:    wpoint = '{x: '0,    y: '0};
          2'd1:    wpoint = '{x: right, y: '0};
          2'd2:    wpoint = '{x: right, y: bottom};
          default: wpoint = '{x: '0,    y: bottom};
        endcase
        if (seed_q == 2'd3) begin
          count_next   = CW'(4);
          count_d      = count_next;
          done_d       = 1'b1;
          res_d.status = STAT_START;
        end
      end
      ST_SCAN: begin
        re       = 1'b1;
        rd_vld_d = 1'b1;
        idx_d    = idx_q + AW'(1);
      end
      ST_DRAIN: begin
        if (drained) begin
          done_d = 1'b1;
          if (dist_stat.close) begin
            res_d.status = STAT_CLOSE;
          end else if (count_q == CW'(MAX_POINTS)) begin
            res_d.status = STAT_FULL;
          end else begin
            we           = 1'b1;
            count_next   = count_q + CW'(1);
            count_d      = count_next;
            res_d.status = STAT_KEPT;
          end
        end
      end
      default: ;
    endcase
    count_wide = {{COUNT_OUT_W{1'b0}}, count_next};
    if (done_d) begin
      res_d.kept_count = count_wide[COUNT_OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      seed_q   <= '0;
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
      done_q   <= 1'b0;
      width_q  <= RST_IMAGE_WIDTH;
      height_q <= RST_IMAGE_HEIGHT;
      limit_q  <= RST_MIN_DIST_SQ;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      seed_q   <= seed_d;
      idx_q    <= idx_d;
      rd_vld_q <= rd_vld_d;
      done_q   <= done_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_IMAGE_WIDTH:  width_q  <= cfg_wdata_i[DIM_W-1:0];
          CFG_IMAGE_HEIGHT: height_q <= cfg_wdata_i[DIM_W-1:0];
          CFG_MIN_DIST_SQ:  limit_q  <= cfg_wdata_i[LIMIT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pt_q  <= pt_d;
    res_q <= res_d;
  end

  mdpt_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_POINTS)
  ) u_list (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wpoint),
    .re_i   (re),
    .raddr_i(idx_q),
    .rdata_o(rpoint)
  );

  mdpt_dist u_dist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .clear_i(clear),
    .vld_i  (rd_vld_q),
    .entry_i(rpoint),
    .pt_i   (pt_q),
    .limit_i(limit_q),
    .stat_o (dist_stat)
  );

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

  `MDPT_ASSERT_SAME(a_scan_in_range, state_q == ST_SCAN, CW'(idx_q) < count_q, "scan past list end")
  `MDPT_ASSERT_SAME(a_count_bound, 1'b1, count_q <= CW'(MAX_POINTS), "kept count above capacity")
  `MDPT_ASSERT_SAME(a_count_with_done, count_q != $past(count_q), done_q, "count moved without result")
  `MDPT_ASSERT_NEXT(a_start_done, accept && (cmd_i.command == CMD_START), ##4 (done_q && (res_q.status == STAT_START)), "start result not on time")
  `MDPT_ASSERT_NEXT(a_corner_done, accept && (cmd_i.command == CMD_OFFER) && corner, (done_q && (res_q.status == STAT_CORNER)), "corner result not on time")

endmodule

// ===== design/mdpt_ram.sv =====
`timescale 1ns / 1ps

module mdpt_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/mdpt_dist.sv =====
`timescale 1ns / 1ps

module mdpt_dist (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           clear_i,
  input  logic                           vld_i,
  input  mdpt_pkg::point_t               entry_i,
  input  mdpt_pkg::point_t               pt_i,
  input  logic [mdpt_pkg::LIMIT_W-1:0]   limit_i,
  output mdpt_pkg::dist_stat_t           stat_o
);

  import mdpt_pkg::*;

  logic [COORD_W-1:0] dx, dy;
  logic [SQ_W-1:0]    sqx_d, sqy_d, sqx_q, sqy_q;
  logic [SQ_W:0]      sum;
  logic               sq_vld_q, close_q, close_d;

  always_comb begin
    dx    = (entry_i.x > pt_i.x) ? entry_i.x - pt_i.x : pt_i.x - entry_i.x;
    dy    = (entry_i.y > pt_i.y) ? entry_i.y - pt_i.y : pt_i.y - entry_i.y;
    sqx_d = SQ_W'(dx) * SQ_W'(dx);
    sqy_d = SQ_W'(dy) * SQ_W'(dy);
  end

  always_comb begin
    sum     = {1'b0, sqx_q} + {1'b0, sqy_q};
    close_d = close_q;
    if (clear_i) begin
      close_d = 1'b0;
    end else if (sq_vld_q && (LIMIT_W'(sum) < limit_i)) begin
      close_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld_q <= 1'b0;
      close_q  <= 1'b0;
    end else begin
      sq_vld_q <= vld_i;
      close_q  <= close_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_i) begin
      sqx_q <= sqx_d;
      sqy_q <= sqy_d;
    end
  end

  assign stat_o.pending = sq_vld_q;
  assign stat_o.close   = close_q;

endmodule
